@@ src/wlac_pkg.sv @@
// Package: sizes, codes, payload and state types of the lag autocorrelation core.
`default_nettype none

package wlac_pkg;

  localparam int WINDOW_LEN = 128;
  localparam int MIN_LAG    = 32;

  localparam int LAG_COUNT = (MIN_LAG < WINDOW_LEN) ? (WINDOW_LEN - MIN_LAG) : 0;
  localparam int LAG_DEPTH = (LAG_COUNT > 0) ? LAG_COUNT : 1;
  localparam int LAG_AW    = (LAG_DEPTH > 1) ? $clog2(LAG_DEPTH) : 1;
  localparam int IDX_W     = $clog2(WINDOW_LEN);
  localparam int WIN_AW    = $clog2(2 * WINDOW_LEN);
  localparam int POS_W     = WIN_AW + 1;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 48;
  localparam int SEL_W    = 7;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_RD,
    S_A_WAIT,
    S_MAC,
    S_DRAIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [SAMPLE_W-1:0] power_sample;
    logic [SEL_W-1:0]    lag_select;
  } in_t;

  typedef struct packed {
    logic [SEL_W-1:0] lag_echo;
    logic [SUM_W-1:0] lag_sum;
  } out_t;

endpackage

`default_nettype wire

@@ src/windowed_lag_autocorrelation_core.sv @@
// Top level: ping-pong sample windows with one shared multiply-accumulate unit over lag sums.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i
//   out     | output    | out_valid_o / out_ready_i| out_data_o
//
// A push that does not fill a window, a clear or an ignored action leaves the core idle; a read
// passes through the response state, with any wait for the output register there. The push that
// completes a window starts a correlation over all LAG_COUNT lags, paced by the single multiplier
// and saturating adder with one read port on each store; no request is taken until it ends.
// Reset and clear take effect at once; window rows and lag sums carry valid bits.
// in_ready_o is low while a request is in work; a stalled result holds in the output register.
`default_nettype none

module windowed_lag_autocorrelation_core
  import wlac_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output out_t out_data_o
);

  logic [SAMPLE_W-1:0] win_mem [2*WINDOW_LEN];
  logic [SUM_W-1:0]    lag_mem [LAG_DEPTH];

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    fill_q, fill_d;
  logic                half_q, half_d;
  logic [1:0]          rowv_q, rowv_d;
  logic [IDX_W-1:0]    i_q, i_d;
  logic [LAG_AW-1:0]   k_q, k_d;
  logic [SAMPLE_W-1:0] a_q, a_d;
  logic [SEL_W-1:0]    sel_q, sel_d;
  logic                inr_q, inr_d;
  logic [LAG_DEPTH-1:0] lag_vld_q;

  logic [SAMPLE_W-1:0] win_rdata_q;
  logic [SUM_W-1:0]    lag_rdata_q;
  logic                lag_rv_q;

  logic                s1_v_q, s2_v_q;
  logic [LAG_AW-1:0]   s1_k_q, s2_k_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SUM_W-1:0]    acc_q;

  logic                out_v_q;
  out_t                out_q;

  logic                win_we, win_re, lag_re, issue, clr_lag, out_load, sel_in_range;
  logic [WIN_AW-1:0]   win_raddr, win_waddr, cur_base, prev_base, b_addr;
  logic [LAG_AW-1:0]   lag_raddr;
  logic [POS_W-1:0]    pos;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;

  assign cur_base  = half_q ? WIN_AW'(WINDOW_LEN) : '0;
  assign prev_base = half_q ? '0 : WIN_AW'(WINDOW_LEN);
  assign win_waddr = cur_base + WIN_AW'(fill_q);
  assign pos       = POS_W'(i_q) + POS_W'(MIN_LAG) + POS_W'(k_q);
  assign b_addr    = (pos < POS_W'(WINDOW_LEN)) ? prev_base + WIN_AW'(pos)
                                                : cur_base + WIN_AW'(pos - POS_W'(WINDOW_LEN));
  assign sel_in_range = (32'(in_data_i.lag_select) < LAG_COUNT);

  assign sum_wide = {1'b0, acc_q} + (SUM_W + 1)'(prod_q);
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    half_d    = half_q;
    rowv_d    = rowv_q;
    i_d       = i_q;
    k_d       = k_q;
    a_d       = a_q;
    sel_d     = sel_q;
    inr_d     = inr_q;
    win_we    = 1'b0;
    win_re    = 1'b0;
    win_raddr = b_addr;
    lag_re    = 1'b0;
    lag_raddr = k_q;
    issue     = 1'b0;
    clr_lag   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.action)
            ACT_PUSH: begin
              win_we = 1'b1;
              if (fill_q == IDX_W'(WINDOW_LEN - 1)) begin
                fill_d         = '0;
                rowv_d[half_q] = 1'b1;
                i_d            = '0;
                k_d            = '0;
                if (LAG_COUNT > 0) begin
                  state_d = S_A_RD;
                end else begin
                  half_d = ~half_q;
                end
              end else begin
                fill_d = fill_q + 1'b1;
              end
            end
            ACT_READ: begin
              lag_re    = 1'b1;
              lag_raddr = sel_in_range ? LAG_AW'(in_data_i.lag_select) : '0;
              sel_d     = in_data_i.lag_select;
              inr_d     = sel_in_range;
              state_d   = S_RESP;
            end
            ACT_CLEAR: begin
              fill_d  = '0;
              half_d  = 1'b0;
              rowv_d  = '0;
              clr_lag = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_A_RD: begin
        win_re    = 1'b1;
        win_raddr = prev_base + WIN_AW'(i_q);
        state_d   = S_A_WAIT;
      end
      S_A_WAIT: begin
        a_d     = rowv_q[~half_q] ? win_rdata_q : '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        win_re = 1'b1;
        lag_re = 1'b1;
        issue  = 1'b1;
        if (k_q == LAG_AW'(LAG_DEPTH - 1)) begin
          k_d = '0;
          if (i_q == IDX_W'(WINDOW_LEN - 1)) begin
            state_d = S_DRAIN;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_A_RD;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          half_d  = ~half_q;
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (!out_v_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      half_q    <= 1'b0;
      rowv_q    <= '0;
      i_q       <= '0;
      k_q       <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      lag_vld_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      half_q  <= half_d;
      rowv_q  <= rowv_d;
      i_q     <= i_d;
      k_q     <= k_d;
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (clr_lag) begin
        lag_vld_q <= '0;
      end else if (s2_v_q) begin
        lag_vld_q[s2_k_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    sel_q  <= sel_d;
    inr_q  <= inr_d;
    s1_k_q <= k_q;
    s2_k_q <= s1_k_q;
    prod_q <= PROD_W'({16'b0, a_q} * {16'b0, win_rdata_q});
    acc_q  <= lag_rv_q ? lag_rdata_q : '0;
    if (out_load) begin
      out_q.lag_echo <= sel_q;
      out_q.lag_sum  <= (inr_q && lag_rv_q) ? lag_rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_waddr] <= in_data_i.power_sample;
    end
    if (win_re) begin
      win_rdata_q <= win_mem[win_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      lag_mem[s2_k_q] <= sum_sat;
    end
    if (lag_re) begin
      lag_rdata_q <= lag_mem[lag_raddr];
      lag_rv_q    <= lag_vld_q[lag_raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/wlac_checker.sv @@
// Checker: port-level properties of the lag autocorrelation core, bound to the top level.
`default_nettype none

module wlac_checker
  import wlac_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  in_valid_i,
  input wire  in_ready_o,
  input in_t  in_data_i,
  input wire  out_valid_o,
  input wire  out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.action == ACT_READ) |=> !in_ready_o)
    else $error("ready while a read request is in work");

  a_clear_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.action == ACT_CLEAR) |=> in_ready_o)
    else $error("not ready after a clear request");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_data_o.lag_echo) >= LAG_COUNT) |-> (out_data_o.lag_sum == '0))
    else $error("nonzero sum for a lag out of range");

endmodule

bind windowed_lag_autocorrelation_core wlac_checker u_wlac_checker (.*);

`default_nettype wire

@@ verif/windowed_lag_autocorrelation_core_tb.sv @@
// Testbench: randomized push/read/clear traffic for the lag autocorrelation core, self-checked.
`timescale 1ns / 1ps

module windowed_lag_autocorrelation_core_tb;
  import wlac_pkg::*;

  localparam logic [1:0]  ACT_IGNORED = 2'd3;
  localparam logic [63:0] SUM_FULL    = 64'h0000_FFFF_FFFF_FFFF;
  localparam int          SEL_MAX     = (1 << SEL_W) - 1;
  localparam int          TARGET_REQS = 1700;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          TAIL_CYCLES = WINDOW_LEN * (LAG_COUNT + 2) + 16;
  localparam int          IDLE_LIMIT  = 100000;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  always #10 clk_i = ~clk_i;

  windowed_lag_autocorrelation_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  in_t              req_q[$];
  out_t             pending_lag_reads[$];
  int unsigned      total_reqs   = 0;
  int unsigned      counted_reqs = 0;
  int unsigned      accepted_cnt = 0;
  int unsigned      fail_cnt     = 0;

  logic [SAMPLE_W-1:0] win_mem [0:2*WINDOW_LEN-1];
  logic [SUM_W-1:0]    lag_acc [0:LAG_DEPTH-1];
  int unsigned         fill_pos;
  bit                  cur_half;

  task automatic add_request(logic [1:0] act, logic [SAMPLE_W-1:0] smp, logic [SEL_W-1:0] sel);
    in_t req;
    req.action       = act;
    req.power_sample = smp;
    req.lag_select   = sel;
    req_q = {req_q, req};
    total_reqs++;
    if (act != ACT_IGNORED) counted_reqs++;
  endtask

  function automatic void corr_clear();
    for (int n = 0; n < 2 * WINDOW_LEN; n++) win_mem[n] = '0;
    for (int n = 0; n < LAG_DEPTH; n++) lag_acc[n] = '0;
    fill_pos = 0;
    cur_half = 1'b0;
  endfunction

  function automatic void corr_fold_window();
    int unsigned cur_base;
    int unsigned prev_base;
    int unsigned p;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] s;
    cur_base  = cur_half ? WINDOW_LEN : 0;
    prev_base = cur_half ? 0 : WINDOW_LEN;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      a = 64'(win_mem[prev_base + i]);
      for (int k = 0; k < LAG_COUNT; k++) begin
        p = i + MIN_LAG + k;
        if (p < WINDOW_LEN) begin
          b = 64'(win_mem[prev_base + p]);
        end else begin
          b = 64'(win_mem[cur_base + ((p - WINDOW_LEN) % WINDOW_LEN)]);
        end
        s = {16'b0, lag_acc[k]} + a * b;
        lag_acc[k] = (s > SUM_FULL) ? SUM_FULL[SUM_W-1:0] : s[SUM_W-1:0];
      end
    end
    cur_half = ~cur_half;
    fill_pos = 0;
  endfunction

  function automatic void corr_apply_request(in_t req);
    out_t rsp;
    case (req.action)
      ACT_PUSH: begin
        win_mem[(cur_half ? WINDOW_LEN : 0) + fill_pos] = req.power_sample;
        fill_pos++;
        if (fill_pos >= WINDOW_LEN) corr_fold_window();
      end
      ACT_READ: begin
        rsp.lag_echo = req.lag_select;
        if (req.lag_select < LAG_COUNT) begin
          rsp.lag_sum = lag_acc[req.lag_select];
        end else begin
          rsp.lag_sum = '0;
        end
        pending_lag_reads = {pending_lag_reads, rsp};
      end
      ACT_CLEAR: corr_clear();
      default: ;
    endcase
  endfunction

  // driver
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        corr_apply_request(in_data);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_data  <= req_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int unsigned rx_cycle  = 0;
  int unsigned seen_cnt  = 0;
  int unsigned hold_at   = 12;
  int          hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (out_valid_o && out_ready) begin
        seen_cnt <= seen_cnt + 1;
        if (pending_lag_reads.size() == 0) begin
          $error("unexpected result: lag_echo %0d lag_sum %0d",
                 out_data_o.lag_echo, out_data_o.lag_sum);
          fail_cnt++;
        end else begin
          want = pending_lag_reads.pop_front();
          if (out_data_o.lag_echo !== want.lag_echo) begin
            $error("lag_echo: expected %0d, actual %0d", want.lag_echo, out_data_o.lag_echo);
            fail_cnt++;
          end
          if (out_data_o.lag_sum !== want.lag_sum) begin
            $error("lag_sum: expected %0d, actual %0d", want.lag_sum, out_data_o.lag_sum);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid_o && out_ready && seen_cnt + 1 == hold_at) begin
        // hold off long enough for the input side to back up
        hold_left <= HOLD_CYCLES;
        hold_at   <= hold_at + 150;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) & 3)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** windowed_lag_autocorrelation_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int kind;
    int style;
    int run_len;
    logic [SAMPLE_W-1:0] smp;
    logic [SEL_W-1:0]    sel;

    corr_clear();

    add_request(ACT_READ, 16'h0000, 7'd0);
    add_request(ACT_READ, 16'hFFFF, SEL_W'(LAG_COUNT - 1));
    add_request(ACT_READ, 16'h0000, SEL_W'(LAG_COUNT));
    add_request(ACT_READ, 16'hFFFF, SEL_W'(SEL_MAX));
    add_request(ACT_IGNORED, 16'hFFFF, SEL_W'(SEL_MAX));
    add_request(ACT_PUSH, 16'hFFFF, 7'd0);
    add_request(ACT_PUSH, 16'h0000, SEL_W'(SEL_MAX));
    add_request(ACT_PUSH, 16'h5A5A, 7'd42);
    add_request(ACT_IGNORED, 16'h0000, 7'd0);
    add_request(ACT_READ, 16'hFFFF, 7'd0);
    add_request(ACT_CLEAR, 16'hFFFF, SEL_W'(SEL_MAX));
    add_request(ACT_READ, 16'h0000, 7'd63);
    add_request(ACT_PUSH, 16'hA5A5, 7'd0);
    add_request(ACT_PUSH, 16'hFFFF, 7'd0);
    add_request(ACT_CLEAR, 16'h0000, 7'd0);
    add_request(ACT_READ, 16'h0000, 7'd1);

    while (counted_reqs < TARGET_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        style   = $urandom_range(0, 4);
        run_len = $urandom_range(96, 200);
        for (int j = 0; j < run_len; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            sel = ($urandom_range(0, 3) == 0) ? SEL_W'($urandom_range(LAG_COUNT, SEL_MAX))
                                              : SEL_W'($urandom_range(0, LAG_COUNT - 1));
            add_request(ACT_READ, SAMPLE_W'($urandom_range(0, 65535)), sel);
          end
          case (style)
            0:       smp = SAMPLE_W'($urandom_range(0, 65535));
            1:       smp = 16'hFFFF;
            2:       smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3:       smp = SAMPLE_W'($urandom_range(0, 255));
            default: smp = {8'($urandom_range(192, 255)), 8'($urandom_range(0, 255))};
          endcase
          add_request(ACT_PUSH, smp, SEL_W'($urandom_range(0, SEL_MAX)));
        end
      end else if (kind < 80) begin
        add_request(ACT_CLEAR, SAMPLE_W'($urandom_range(0, 65535)),
                    SEL_W'($urandom_range(0, SEL_MAX)));
      end else if (kind < 90) begin
        run_len = $urandom_range(1, 6);
        for (int j = 0; j < run_len; j++) begin
          add_request(ACT_READ, SAMPLE_W'($urandom_range(0, 65535)),
                      SEL_W'($urandom_range(0, SEL_MAX)));
        end
      end else if (kind < 95) begin
        run_len = $urandom_range(1, 5);
        for (int j = 0; j < run_len; j++) begin
          add_request(2'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 65535)),
                      SEL_W'($urandom_range(0, SEL_MAX)));
        end
      end else begin
        run_len = $urandom_range(1, 20);
        for (int j = 0; j < run_len; j++) begin
          add_request(ACT_PUSH, SAMPLE_W'($urandom_range(0, 65535)),
                      SEL_W'($urandom_range(0, SEL_MAX)));
        end
      end
    end

    for (int j = 0; j <= SEL_MAX; j++) begin
      add_request(ACT_READ, SAMPLE_W'($urandom_range(0, 65535)), SEL_W'(j));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_reqs) @(posedge clk_i);
    while (pending_lag_reads.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("** windowed_lag_autocorrelation_core: PASSED **");
    end else begin
      $display("** windowed_lag_autocorrelation_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/wlac_pkg.sv
src/windowed_lag_autocorrelation_core.sv
src/wlac_checker.sv
verif/windowed_lag_autocorrelation_core_tb.sv
